FILE: hdl/tsca_pkg.sv
// ----------------------------------------------------------------------------
// tsca_pkg
// Shared types and constants for the tone symbol character assembler.
// ----------------------------------------------------------------------------
package tsca_pkg;

  // character geometry
  localparam int unsigned BITS_PER_CHAR = 8;
  localparam int unsigned CNT_W         = 4;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BITS_PER_CHAR);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(BITS_PER_CHAR + 1);

  // tone frequencies in Hz
  localparam logic [15:0] FREQ_ZERO_A = 16'd39145;
  localparam logic [15:0] FREQ_ZERO_B = 16'd39474;
  localparam logic [15:0] FREQ_ZERO_C = 16'd39803;
  localparam logic [15:0] FREQ_MARK   = 16'd40132;
  localparam logic [15:0] FREQ_ONE_A  = 16'd40461;
  localparam logic [15:0] FREQ_ONE_B  = 16'd40789;
  localparam logic [15:0] FREQ_ONE_C  = 16'd41118;

  // symbol codes
  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_MARK = 2'd2
  } sym_t;

  // result kinds and fixed characters
  localparam logic       KIND_CHAR = 1'b0;
  localparam logic       KIND_END  = 1'b1;
  localparam logic [7:0] ERR_CHAR  = 8'd63;
  localparam logic [7:0] END_CHAR  = 8'd0;

  // command queue geometry
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_DEPTH = 1 << Q_AW;

  // one closed run: one or two result beats
  typedef struct packed {
    logic       two;      // a second character beat follows
    logic       r0_kind;
    logic [7:0] r0_char;
    logic [7:0] r1_char;  // second beat is always a character
  } cmd_t;

  // frequency to symbol map
  function automatic sym_t map_freq(input logic [15:0] f);
    sym_t s;
    case (f)
      FREQ_ZERO_A, FREQ_ZERO_B, FREQ_ZERO_C: s = SYM_ZERO;
      FREQ_MARK:                             s = SYM_MARK;
      FREQ_ONE_A, FREQ_ONE_B, FREQ_ONE_C:    s = SYM_ONE;
      default:                               s = SYM_ZERO;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/tsca_front.sv
// ----------------------------------------------------------------------------
// tsca_front
// Accepts symbol slots, collects the run and, on each silent slot, builds
// the result command for the back end, if the run or open message yields one.
// ----------------------------------------------------------------------------
module tsca_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_tone_present,
  input  logic [15:0]         in_tone_freq,
  input  logic                q_full,
  output logic                push,
  output tsca_pkg::cmd_t      push_cmd
);

  logic [tsca_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic                       marker_r, marker_nxt;
  logic                       open_r, open_nxt;
  logic                       accept;
  tsca_pkg::sym_t             sym;
  logic                       err_first;
  logic                       byte_nz;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign sym      = tsca_pkg::map_freq(in_tone_freq);
  assign err_first = marker_r && open_r;
  assign byte_nz   = (shift_r != 8'd0);

  // run update and command build
  always_comb begin
    count_nxt  = count_r;
    shift_nxt  = shift_r;
    marker_nxt = marker_r;
    open_nxt   = open_r;
    push       = 1'b0;
    push_cmd   = '{two: 1'b0, r0_kind: tsca_pkg::KIND_CHAR,
                   r0_char: tsca_pkg::ERR_CHAR, r1_char: shift_r};
    if (accept) begin
      if (in_tone_present) begin
        if (count_r < tsca_pkg::CNT_SAT) begin
          count_nxt = count_r + 1'b1;
        end
        if (!marker_r) begin
          if (sym == tsca_pkg::SYM_MARK) begin
            marker_nxt = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], (sym == tsca_pkg::SYM_ONE)};
          end
        end
      end else begin
        count_nxt  = '0;
        shift_nxt  = 8'd0;
        marker_nxt = 1'b0;
        if (count_r == '0) begin
          // empty run closes an open message
          if (open_r) begin
            push             = 1'b1;
            push_cmd.r0_kind = tsca_pkg::KIND_END;
            push_cmd.r0_char = tsca_pkg::END_CHAR;
            open_nxt         = 1'b0;
          end
        end else if (count_r != tsca_pkg::CNT_FULL) begin
          // wrong length
          push     = 1'b1;
          open_nxt = 1'b1;
        end else begin
          // full run: optional error mark, then byte if nonzero
          push         = err_first || byte_nz;
          push_cmd.two = err_first && byte_nz;
          if (!err_first) begin
            push_cmd.r0_char = shift_r;
          end
          open_nxt = open_r || err_first || byte_nz;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      shift_r  <= 8'd0;
      marker_r <= 1'b0;
      open_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      shift_r  <= shift_nxt;
      marker_r <= marker_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule

FILE: hdl/tsca_queue.sv
// ----------------------------------------------------------------------------
// tsca_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module tsca_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tsca_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tsca_pkg::cmd_t head
);

  tsca_pkg::cmd_t              mem [tsca_pkg::Q_DEPTH];
  tsca_pkg::cmd_t              head_r;
  logic [tsca_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r, rd_ptr_nxt;
  logic [tsca_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                        do_pop;

  assign full       = (cnt_r == (tsca_pkg::Q_AW+1)'(tsca_pkg::Q_DEPTH));
  assign not_empty  = (cnt_r != '0);
  assign head       = head_r;
  assign do_pop     = pop && not_empty;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // storage; the head word is read ahead, with a bypass when the new
  // entry lands at the next head address
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_cmd;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/tsca_back.sv
// ----------------------------------------------------------------------------
// tsca_back
// Expands queued commands into result beats through an output register.
// ----------------------------------------------------------------------------
module tsca_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  tsca_pkg::cmd_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_result_kind,
  output logic [7:0]     out_char_value,
  output logic           out_last_of_run
);

  logic       valid_r, valid_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       sec_pend_r, sec_pend_nxt;
  logic [7:0] sec_char_r, sec_char_nxt;
  logic       load;

  assign load = !valid_r || !out_stall;

  // next beat selection
  always_comb begin
    valid_nxt    = valid_r;
    kind_nxt     = kind_r;
    char_nxt     = char_r;
    last_nxt     = last_r;
    sec_pend_nxt = sec_pend_r;
    sec_char_nxt = sec_char_r;
    pop          = 1'b0;
    if (load) begin
      if (sec_pend_r) begin
        valid_nxt    = 1'b1;
        kind_nxt     = tsca_pkg::KIND_CHAR;
        char_nxt     = sec_char_r;
        last_nxt     = 1'b1;
        sec_pend_nxt = 1'b0;
      end else if (q_not_empty) begin
        pop          = 1'b1;
        valid_nxt    = 1'b1;
        kind_nxt     = q_head.r0_kind;
        char_nxt     = q_head.r0_char;
        last_nxt     = !q_head.two;
        sec_pend_nxt = q_head.two;
        sec_char_nxt = q_head.r1_char;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sec_pend_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      sec_pend_r <= sec_pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    char_r     <= char_nxt;
    last_r     <= last_nxt;
    sec_char_r <= sec_char_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_char_value  = char_r;
  assign out_last_of_run = last_r;

endmodule

FILE: hdl/tone_symbol_char_assembler_core.sv
// ----------------------------------------------------------------------------
// tone_symbol_char_assembler_core
// Path: the first result of a silent slot is registered in the command queue, then in the output register.
// Throughput: one slot per cycle unless the queue is full; a slot with two results gives two output beats.
// A four-entry command queue absorbs bursts; input stalls only when it is full.
// Reset: synchronous, active low; clears the run, message flag, queue and output.
// ----------------------------------------------------------------------------
module tone_symbol_char_assembler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_tone_present,
  input  logic [15:0] in_tone_freq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_char_value,
  output logic        out_last_of_run
);

  logic           push;
  tsca_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  logic           q_not_empty;
  tsca_pkg::cmd_t q_head;

  // slot intake and run tracking
  tsca_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tone_present (in_tone_present),
    .in_tone_freq    (in_tone_freq),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // command queue
  tsca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // result beats
  tsca_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_char_value  (out_char_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: bench/tb_tone_symbol_char_assembler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tone_symbol_char_assembler_core
// Drives symbol slots into the assembler and checks every character and
// end-of-message beat against an in-bench model of the run and message state.
// ----------------------------------------------------------------------------
module tb_tone_symbol_char_assembler_core;

  // Tracks the symbol run and message state, holds the beats still owed.
  class char_checker;
    typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic       last;
    } beat_t;

    beat_t       owed_beats[$];
    logic [3:0]  run_len;
    logic [7:0]  run_bits;
    logic        run_marked;
    logic        msg_open;
    int unsigned errors;

    function new();
      run_len    = '0;
      run_bits   = '0;
      run_marked = 1'b0;
      msg_open   = 1'b0;
      errors     = 0;
    endfunction

    // tone bin to symbol; anything off the table reads as a zero bit
    function tsca_pkg::sym_t decode_tone(logic [15:0] freq);
      tsca_pkg::sym_t s;
      if (freq == tsca_pkg::FREQ_MARK) s = tsca_pkg::SYM_MARK;
      else if (freq == tsca_pkg::FREQ_ONE_A || freq == tsca_pkg::FREQ_ONE_B ||
               freq == tsca_pkg::FREQ_ONE_C) s = tsca_pkg::SYM_ONE;
      else s = tsca_pkg::SYM_ZERO;
      return s;
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    // one accepted slot: extend the run, or close it and queue its beats
    function void note_slot(logic present, logic [15:0] freq);
      beat_t fresh[$];
      beat_t b;
      tsca_pkg::sym_t s;
      if (present) begin
        s = decode_tone(freq);
        if (run_len < tsca_pkg::CNT_SAT) run_len++;
        if (!run_marked) begin
          if (s == tsca_pkg::SYM_MARK) run_marked = 1'b1;
          else run_bits = {run_bits[6:0], s == tsca_pkg::SYM_ONE};
        end
        return;
      end
      b.last = 1'b0;
      if (run_len == '0) begin
        if (msg_open) begin
          b.kind = tsca_pkg::KIND_END;
          b.ch   = tsca_pkg::END_CHAR;
          fresh  = {fresh, b};
          msg_open = 1'b0;
        end
      end else if (run_len != tsca_pkg::CNT_FULL) begin
        b.kind = tsca_pkg::KIND_CHAR;
        b.ch   = tsca_pkg::ERR_CHAR;
        fresh  = {fresh, b};
        msg_open = 1'b1;
      end else begin
        b.kind = tsca_pkg::KIND_CHAR;
        if (run_marked && msg_open) begin
          b.ch  = tsca_pkg::ERR_CHAR;
          fresh = {fresh, b};
        end
        if (run_bits != 8'd0) begin
          b.ch  = run_bits;
          fresh = {fresh, b};
        end
        if (fresh.size() != 0) msg_open = 1'b1;
      end
      if (fresh.size() != 0) fresh[fresh.size()-1].last = 1'b1;
      owed_beats = {owed_beats, fresh};
      run_len    = '0;
      run_bits   = '0;
      run_marked = 1'b0;
    endfunction

    // one accepted result beat against the oldest owed beat
    function void check_beat(logic kind, logic [7:0] ch, logic last);
      beat_t w;
      if (owed_beats.size() == 0) begin
        flag($sformatf("unexpected beat kind=%0d char=%0d last=%0d", kind, ch, last));
        return;
      end
      w = owed_beats.pop_front();
      if (w.kind !== kind || w.ch !== ch || w.last !== last)
        flag($sformatf("expected kind=%0d char=%0d last=%0d, got kind=%0d char=%0d last=%0d",
                       w.kind, w.ch, w.last, kind, ch, last));
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    function void close_out();
      if (owed_beats.size() != 0)
        flag($sformatf("%0d beats never arrived", owed_beats.size()));
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_tone_present = 1'b0;
  logic [15:0] in_tone_freq    = 16'd0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_result_kind;
  logic [7:0]  out_char_value;
  logic        out_last_of_run;

  char_checker chk = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned slots_sent     = 0;

  tone_symbol_char_assembler_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tone_present (in_tone_present),
    .in_tone_freq    (in_tone_freq),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_char_value  (out_char_value),
    .out_last_of_run (out_last_of_run)
  );

  always #4 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // beat monitors on both channels
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      chk.check_beat(out_result_kind, out_char_value, out_last_of_run);
    if (rst_n && in_valid && !in_stall)
      chk.note_slot(in_tone_present, in_tone_freq);
  end

  // one slot beat, with optional idle cycles ahead of it
  task automatic send_slot(input logic present, input logic [15:0] freq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_tone_present <= present;
    in_tone_freq    <= freq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slots_sent++;
  endtask

  // pick a tone bin for a symbol; zero bits sometimes use an off-table bin
  function automatic logic [15:0] tone_for(tsca_pkg::sym_t s);
    logic [15:0] f;
    case (s)
      tsca_pkg::SYM_MARK: f = tsca_pkg::FREQ_MARK;
      tsca_pkg::SYM_ONE: begin
        case ($urandom_range(0, 2))
          0:       f = tsca_pkg::FREQ_ONE_A;
          1:       f = tsca_pkg::FREQ_ONE_B;
          default: f = tsca_pkg::FREQ_ONE_C;
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       f = tsca_pkg::FREQ_ZERO_A;
          1:       f = tsca_pkg::FREQ_ZERO_B;
          2:       f = tsca_pkg::FREQ_ZERO_C;
          default: f = 16'($urandom_range(0, 65535));
        endcase
      end
    endcase
    return f;
  endfunction

  // a run of tones (marker at mark_at, none if out of range), then silence
  task automatic send_run(input int len, input logic [7:0] value, input int mark_at);
    tsca_pkg::sym_t s;
    for (int i = 0; i < len; i++) begin
      if (i == mark_at) s = tsca_pkg::SYM_MARK;
      else if (i < 8) s = value[7-i] ? tsca_pkg::SYM_ONE : tsca_pkg::SYM_ZERO;
      else s = $urandom_range(0, 1) ? tsca_pkg::SYM_ONE : tsca_pkg::SYM_ZERO;
      send_slot(1'b1, tone_for(s));
    end
    send_slot(1'b0, 16'($urandom_range(0, 65535)));
  endtask

  // edge cases: idle close, every bin, unknown bins, short run, marker, ends
  task automatic run_directed();
    logic [15:0] c_bins [8];
    c_bins = '{tsca_pkg::FREQ_ZERO_A, tsca_pkg::FREQ_ONE_A, tsca_pkg::FREQ_ZERO_B,
               tsca_pkg::FREQ_ZERO_C, 16'h0000, 16'hFFFF, tsca_pkg::FREQ_ONE_B,
               tsca_pkg::FREQ_ONE_C};
    send_slot(1'b0, 16'h0000);          // silence with message closed
    foreach (c_bins[i]) send_slot(1'b1, c_bins[i]);
    send_slot(1'b0, 16'hFFFF);          // 'C'
    send_slot(1'b0, 16'h0000);          // end of message
    send_slot(1'b1, tsca_pkg::FREQ_ONE_A);
    send_slot(1'b0, 16'h5555);          // short run
    send_run(8, 8'hFF, 3);              // marker with message open: two beats
    send_slot(1'b0, 16'hAAAA);          // end of message
  endtask

  // mostly well-formed characters, plus ends, bad lengths and noise
  task automatic run_random();
    int unsigned pick;
    int          n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_run(8, 8'($urandom_range(1, 255)),
               ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 7)) : 8);
    end else if (pick < 65) begin
      send_run(8, 8'h00, ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 7)) : 8);
    end else if (pick < 75) begin
      send_slot(1'b0, 16'($urandom_range(0, 65535)));
    end else if (pick < 90) begin
      n = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 7)) : int'($urandom_range(9, 20));
      send_run(n, 8'($urandom_range(0, 255)),
               ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, n - 1)) : 99);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_slot(1'(($urandom_range(0, 99) < 70)), 16'($urandom_range(0, 65535)));
    end
  endtask

  // main sequence
  initial begin
    int unsigned goal;
    int unsigned guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      goal = slots_sent + 138;
      while (slots_sent < goal) run_random();
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray beat
    guard = 0;
    while (chk.pending() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    chk.close_out();
    if (chk.errors == 0) begin
      $display("** tone_symbol_char_assembler_core: PASSED **");
    end else begin
      $display("** tone_symbol_char_assembler_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("** tone_symbol_char_assembler_core: FAILED **");
    $finish;
  end

endmodule
